FILE: rtl/sha512_pkg.sv
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, constants and helper functions of the SHA-512 hash unit.
// ----------------------------------------------------------------------------
package sha512_pkg;

	localparam int unsigned RoundCount = 80;
	localparam int unsigned DigestWords = 8;

	typedef logic [63:0] word_t;

	typedef struct packed {
		logic load_byte;   // pack one byte into the block
		logic pad_start;   // mark end of message, place 0x80
		logic pad_clear;   // zero the block (second pad block)
		logic pad_length;  // write bit length into words 14, 15
		logic comp_start;  // copy chain into working vars
		logic comp_round;  // run one round
		logic comp_finish; // add working vars into chain
		logic out_reset;   // reload initial state
	} dp_cmd_t;

	typedef struct packed {
		logic block_full; // byte position wrapped to zero
		logic had_room;   // tail below 112 bytes
		logic last_round; // round counter at 79
	} dp_stat_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	function automatic word_t init_hash(input logic [2:0] i);
		case (i)
			3'd0: init_hash = 64'h6a09e667f3bcc908;
			3'd1: init_hash = 64'hbb67ae8584caa73b;
			3'd2: init_hash = 64'h3c6ef372fe94f82b;
			3'd3: init_hash = 64'ha54ff53a5f1d36f1;
			3'd4: init_hash = 64'h510e527fade682d1;
			3'd5: init_hash = 64'h9b05688c2b3e6c1f;
			3'd6: init_hash = 64'h1f83d9abfb41bd6b;
			default: init_hash = 64'h5be0cd19137e2179;
		endcase
	endfunction

	localparam word_t RoundConst [RoundCount] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

endpackage

FILE: rtl/sha512_if.sv
// ----------------------------------------------------------------------------
// sha512_in_if / sha512_out_if
// Valid/ready channels carrying message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha512_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_message;
	modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha512_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/sha512_hash_unit.sv
// ----------------------------------------------------------------------------
// sha512_hash_unit
// SHA-512 over a byte stream; eight digest words on end of message.
// ----------------------------------------------------------------------------
// Sequence: each byte passes an intake check before the next is taken; a byte
// that fills a block adds load, 80 rounds of the single round unit and add.
// End of message: 1 or 2 padding blocks, compressed alike, then 8 words.
// Reset: asynchronous, active low; chain value reloads to the initial hash.
module sha512_hash_unit (
	input  logic          clk,
	input  logic          arst_n,
	sha512_in_if.sink     in_ch,
	sha512_out_if.source  out_ch
);

	sha512_pkg::dp_cmd_t  cmd;
	sha512_pkg::dp_stat_t stat;
	logic [2:0]           sel;

	sha512_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_sel   (sel),
		.stat      (stat),
		.cmd       (cmd)
	);

	sha512_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (in_ch.data_byte),
		.out_sel   (sel),
		.stat      (stat),
		.digest    (out_ch.digest_word)
	);

	assign out_ch.word_index = sel;
	assign out_ch.last_word  = (sel == 3'd7);

endmodule

FILE: rtl/sha512_dp.sv
// ----------------------------------------------------------------------------
// sha512_dp
// Block buffer, message schedule, round datapath and chaining value.
// ----------------------------------------------------------------------------
module sha512_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha512_pkg::dp_cmd_t   cmd,
	input  logic [7:0]            data_byte,
	input  logic [2:0]            out_sel,
	output sha512_pkg::dp_stat_t  stat,
	output sha512_pkg::word_t     digest
);

	sha512_pkg::word_t chain_q [8];
	sha512_pkg::word_t var_q [8];
	sha512_pkg::word_t win_q [16];
	logic [63:0]       len_q;
	logic [6:0]        pos_q;
	logic [6:0]        rnd_q;

	sha512_pkg::word_t x15, x2, sm0, sm1, wnew, w, big1, chf, tmp1, big0, maj;
	logic [3:0]        ti;
	logic [6:0]        pos_nx;
	sha512_pkg::word_t bmask;

	assign ti     = rnd_q[3:0];
	assign pos_nx = pos_q + 7'd1;

	always_comb begin
		x15  = win_q[ti + 4'd1];
		x2   = win_q[ti + 4'd14];
		sm0  = sha512_pkg::rotr(x15, 1) ^ sha512_pkg::rotr(x15, 8) ^ (x15 >> 7);
		sm1  = sha512_pkg::rotr(x2, 19) ^ sha512_pkg::rotr(x2, 61) ^ (x2 >> 6);
		wnew = win_q[ti] + sm0 + win_q[ti + 4'd9] + sm1;
		w    = (rnd_q >= 7'd16) ? wnew : win_q[ti];
		big1 = sha512_pkg::rotr(var_q[4], 14) ^ sha512_pkg::rotr(var_q[4], 18)
			^ sha512_pkg::rotr(var_q[4], 41);
		chf  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		tmp1 = var_q[7] + big1 + chf + sha512_pkg::RoundConst[rnd_q] + w;
		big0 = sha512_pkg::rotr(var_q[0], 28) ^ sha512_pkg::rotr(var_q[0], 34)
			^ sha512_pkg::rotr(var_q[0], 39);
		maj  = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		bmask = ~(64'hffffffffffffffff >> {pos_q[2:0], 3'd0});
	end

	assign stat.block_full = (pos_q == 7'd0);
	assign stat.had_room   = (pos_q < 7'd112);
	assign stat.last_round = (rnd_q == 7'd79);
	assign digest          = chain_q[out_sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha512_pkg::init_hash(3'(i));
				var_q[i]   <= '0;
			end
			for (int i = 0; i < 16; i++) win_q[i] <= '0;
			len_q <= '0;
			pos_q <= '0;
			rnd_q <= '0;
		end else begin
			if (cmd.load_byte) begin
				win_q[pos_q[6:3]] <= ((pos_q[2:0] == 3'd0) ? 64'd0 : win_q[pos_q[6:3]])
					| ({56'd0, data_byte} << {~pos_q[2:0], 3'd0});
				pos_q <= pos_nx;
				len_q <= len_q + 64'd8;
			end
			if (cmd.pad_start) begin
				for (int i = 0; i < 16; i++) begin
					if (4'(i) > pos_q[6:3]) win_q[i] <= '0;
				end
				win_q[pos_q[6:3]] <= (win_q[pos_q[6:3]] & bmask)
					| (64'h80 << {~pos_q[2:0], 3'd0});
			end
			if (cmd.pad_clear) begin
				for (int i = 0; i < 16; i++) win_q[i] <= '0;
			end
			if (cmd.pad_length) begin
				win_q[14] <= '0;
				win_q[15] <= len_q;
			end
			if (cmd.comp_start) begin
				for (int i = 0; i < 8; i++) var_q[i] <= chain_q[i];
				rnd_q <= '0;
			end
			if (cmd.comp_round) begin
				if (rnd_q >= 7'd16) win_q[ti] <= wnew;
				var_q[7] <= var_q[6];
				var_q[6] <= var_q[5];
				var_q[5] <= var_q[4];
				var_q[4] <= var_q[3] + tmp1;
				var_q[3] <= var_q[2];
				var_q[2] <= var_q[1];
				var_q[1] <= var_q[0];
				var_q[0] <= tmp1 + big0 + maj;
				rnd_q    <= rnd_q + 7'd1;
			end
			if (cmd.comp_finish) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + var_q[i];
				rnd_q <= '0;
			end
			if (cmd.out_reset) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= sha512_pkg::init_hash(3'(i));
					var_q[i]   <= '0;
				end
				for (int i = 0; i < 16; i++) win_q[i] <= '0;
				len_q <= '0;
				pos_q <= '0;
				rnd_q <= '0;
			end
		end
	end

endmodule

FILE: rtl/sha512_ctrl.sv
// ----------------------------------------------------------------------------
// sha512_ctrl
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha512_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	sha512_in_if.sink            in_ch,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [2:0]           out_sel,
	input  sha512_pkg::dp_stat_t stat,
	output sha512_pkg::dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CHECK = 7'b0000010,
		ST_PAD   = 7'b0000100,
		ST_START = 7'b0001000,
		ST_ROUND = 7'b0010000,
		ST_ADD   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t     state_q;
	logic       eom_q;  // padding still owed after this compression
	logic       fin_q;  // compression is the final one
	logic       two_q;  // a second, zero pad block follows
	logic [2:0] idx_q;
	logic       acc;
	logic       was_byte_q;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign acc         = in_ch.valid && in_ch.ready;
	assign out_valid   = (state_q == ST_OUT);
	assign out_sel     = idx_q;

	always_comb begin
		cmd = '0;
		cmd.load_byte   = acc && in_ch.byte_valid;
		cmd.pad_start   = (state_q == ST_PAD) && !two_q;
		cmd.pad_clear   = (state_q == ST_PAD) && two_q;
		cmd.pad_length  = (state_q == ST_PAD) && (two_q || stat.had_room);
		cmd.comp_start  = (state_q == ST_START);
		cmd.comp_round  = (state_q == ST_ROUND);
		cmd.comp_finish = (state_q == ST_ADD);
		cmd.out_reset   = out_valid && out_ready && (idx_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			eom_q   <= 1'b0;
			fin_q   <= 1'b0;
			two_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						eom_q   <= in_ch.end_of_message;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (stat.block_full && was_byte_q) begin
						state_q <= ST_START;
					end else if (eom_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					fin_q   <= two_q || stat.had_room;
					state_q <= ST_START;
				end
				ST_START: state_q <= ST_ROUND;
				ST_ROUND: if (stat.last_round) state_q <= ST_ADD;
				ST_ADD: begin
					if (fin_q) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else if (eom_q) begin
						two_q   <= !stat.block_full;
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							eom_q   <= 1'b0;
							fin_q   <= 1'b0;
							two_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Note whether the accepted request carried a byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_byte_q <= 1'b0;
		end else begin
			if (acc) was_byte_q <= in_ch.byte_valid;
		end
	end

	chk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ch.ready)
		else $error("input taken while digest pending");
	chk_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && stat.last_round |=> (state_q == ST_ADD))
		else $error("round loop overrun");
	chk_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (idx_q == 3'd0))
		else $error("word index not cleared");

endmodule
